// ----- rtl/psq_pkg.sv -----
// Package for the product scalar quantiser encoder.
// Holds the sequencer state type, register and operation codes, and default sizes.
// No dependencies.
package psq_pkg;

   // default sizes handed to the top level parameters
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_MAX_DIMS    = 8;
   localparam int DEF_SAMPLE_BITS = 16;

   // fixed field widths
   localparam int NUM_SAMPLES = 8;
   localparam int CODE_BITS   = 8;
   localparam int CFG_BITS    = 4;
   localparam int ENTRY_BITS  = 8;

   // configuration register indexes
   localparam logic CSR_BITS_PER_DIM  = 1'b0;
   localparam logic CSR_SUBSPACE_DIMS = 1'b1;

   // reset values and limits of the configuration registers
   localparam logic [CFG_BITS-1:0] BPD_RESET  = 4'd4;
   localparam logic [CFG_BITS-1:0] DIMS_RESET = 4'd2;
   localparam logic [CFG_BITS-1:0] BPD_MAX    = 4'd8;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SEARCH,
      ST_CMP,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/psq_table.sv -----
// Codeword table: one write port and two registered read ports.
// Depends on nothing; sized by the top level.
module psq_table #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr_a,
   input  logic [ADDR_W-1:0]        rd_addr_b,
   output logic signed [DATA_W-1:0] rd_data_a,
   output logic signed [DATA_W-1:0] rd_data_b
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two read ports, data registered
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/product_scalar_quantizer_encoder_unit.sv -----
// Product scalar quantiser encoder, top level: sequencer, shared compare unit, packing.
// Depends on psq_pkg and psq_table.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | operation, entry_index, entry_value, sample_0..7
//  rsp     | out       | rsp_valid / rsp_stall  | code
//  csr     | in        | csr_wr_en              | csr_index, csr_wr_data
//
// A load is taken whenever the block is idle; loads can follow each other every cycle.
// An encode keeps req_stall high while it searches dims samples with p table probes
// each, p being the number of table probes per sample (up to bits_per_dim), and also
// while an earlier result is still stalled when the encode finishes. Each probe is a
// table read in ST_SEARCH and a compare in ST_CMP, as the table has registered read data.
// Synchronous reset clears the sequencer and the result valid; the table is not cleared.
// A stalled result sits in the output register; a new item is taken meanwhile.
module product_scalar_quantizer_encoder_unit #(
   parameter int TABLE_DEPTH = psq_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_DIMS    = psq_pkg::DEF_MAX_DIMS,
   parameter int SAMPLE_BITS = psq_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [psq_pkg::ENTRY_BITS-1:0]      req_entry_index,
   input  logic signed [SAMPLE_BITS-1:0]       req_entry_value,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_0,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_1,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_2,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_3,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_4,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_5,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_6,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_7,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psq_pkg::CODE_BITS-1:0]       rsp_code,
   // configuration port
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [psq_pkg::CFG_BITS-1:0]        csr_wr_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW     = psq_pkg::CFG_BITS;
   localparam int POS_W  = 7;
   localparam logic [psq_pkg::ENTRY_BITS:0] DEPTH_LIM = (psq_pkg::ENTRY_BITS+1)'(TABLE_DEPTH);
   localparam logic [psq_pkg::ENTRY_BITS:0] HI_LIM    = (psq_pkg::ENTRY_BITS+1)'(TABLE_DEPTH-1);
   localparam logic [CW-1:0] DIMS_MAX = CW'(MAX_DIMS);

   // registers
   psq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      bpd_ff, dims_cfg_ff;
   logic [CW-1:0]      b_ff, b_in;
   logic [CW-1:0]      dims_ff, dims_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [psq_pkg::CODE_BITS-1:0] code_ff, code_in;
   logic [ADDR_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SAMPLE_BITS-1:0] s_ff, s_in;
   logic signed [SAMPLE_BITS-1:0] samples_ff [psq_pkg::NUM_SAMPLES];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [psq_pkg::CODE_BITS-1:0] rsp_code_ff, rsp_code_in;

   // control
   logic req_xfer, enc_xfer, tbl_wr_en, out_free;

   // datapath helpers
   logic [CW-1:0]      b_sat, dims_sat;
   logic [psq_pkg::ENTRY_BITS:0] hi_wide, hi_init;
   logic [ADDR_W:0]    mid_sum;
   logic [ADDR_W-1:0]  mid, mid_p1;
   logic signed [SAMPLE_BITS-1:0] rd_a, rd_b;
   logic signed [SAMPLE_BITS:0]   pair_sum, twice_s;
   logic               go_low, search_more, last_sample;
   logic [15:0]        pack_wide;
   logic [psq_pkg::CODE_BITS-1:0] pack_bits;

   // codeword table
   psq_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl_wr_en),
      .wr_addr   (req_entry_index[ADDR_W-1:0]),
      .wr_data   (req_entry_value),
      .rd_addr_a (mid),
      .rd_addr_b (mid_p1),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpd_ff      <= psq_pkg::BPD_RESET;
         dims_cfg_ff <= psq_pkg::DIMS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            psq_pkg::CSR_BITS_PER_DIM:  bpd_ff      <= csr_wr_data;
            psq_pkg::CSR_SUBSPACE_DIMS: dims_cfg_ff <= csr_wr_data;
         endcase
      end
   end

   // saturated settings and initial upper bound of the search
   assign b_sat    = (bpd_ff > psq_pkg::BPD_MAX) ? psq_pkg::BPD_MAX : bpd_ff;
   assign dims_sat = (dims_cfg_ff > DIMS_MAX) ? DIMS_MAX : dims_cfg_ff;
   assign hi_wide  = ((psq_pkg::ENTRY_BITS+1)'(1) << b_ff) - (psq_pkg::ENTRY_BITS+1)'(1);
   assign hi_init  = (hi_wide > HI_LIM) ? HI_LIM : hi_wide;

   // probe addresses and the shared midpoint compare
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[ADDR_W:1];
   assign mid_p1      = mid + ADDR_W'(1);
   assign pair_sum    = (SAMPLE_BITS+1)'(rd_a) + (SAMPLE_BITS+1)'(rd_b);
   assign twice_s     = {s_ff, 1'b0};
   assign go_low      = twice_s < pair_sum;
   assign search_more = lo_ff < hi_ff;
   assign last_sample = (k_ff + CW'(1)) == dims_ff;

   // index placed at its bit position; bits past the code width drop out
   assign pack_wide = 16'(lo_ff) << pos_ff[2:0];
   assign pack_bits = (pos_ff < POS_W'(psq_pkg::CODE_BITS)) ?
                      pack_wide[psq_pkg::CODE_BITS-1:0] : '0;

   // handshake and table write
   always_comb begin
      req_stall = (state_ff != psq_pkg::ST_IDLE);
      req_xfer  = req_valid && !req_stall;
      enc_xfer  = req_xfer && (req_operation == psq_pkg::OP_ENCODE);
      tbl_wr_en = req_xfer && (req_operation == psq_pkg::OP_LOAD) &&
                  ({1'b0, req_entry_index} < DEPTH_LIM);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psq_pkg::ST_IDLE: begin
            if (enc_xfer) begin
               state_in = (dims_sat == '0) ? psq_pkg::ST_FINISH : psq_pkg::ST_SETUP;
            end
         end
         psq_pkg::ST_SETUP:  state_in = psq_pkg::ST_SEARCH;
         psq_pkg::ST_SEARCH: begin
            if (search_more) begin
               state_in = psq_pkg::ST_CMP;
            end else if (last_sample) begin
               state_in = psq_pkg::ST_FINISH;
            end else begin
               state_in = psq_pkg::ST_SETUP;
            end
         end
         psq_pkg::ST_CMP:    state_in = psq_pkg::ST_SEARCH;
         psq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = psq_pkg::ST_IDLE;
            end
         end
         default: state_in = psq_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      b_in         = b_ff;
      dims_in      = dims_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      code_in      = code_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      unique case (state_ff)
         psq_pkg::ST_IDLE: begin
            if (enc_xfer) begin
               b_in    = b_sat;
               dims_in = dims_sat;
               k_in    = '0;
               pos_in  = '0;
               code_in = '0;
            end
         end
         psq_pkg::ST_SETUP: begin
            lo_in = '0;
            hi_in = hi_init[ADDR_W-1:0];
            s_in  = samples_ff[k_ff[2:0]];
         end
         psq_pkg::ST_SEARCH: begin
            if (!search_more) begin
               code_in = code_ff | pack_bits;
               k_in    = k_ff + CW'(1);
               pos_in  = pos_ff + POS_W'(b_ff);
            end
         end
         psq_pkg::ST_CMP: begin
            if (go_low) begin
               hi_in = mid;
            end else begin
               lo_in = mid_p1;
            end
         end
         psq_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b_ff        <= b_in;
      dims_ff     <= dims_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      code_ff     <= code_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      s_ff        <= s_in;
      rsp_code_ff <= rsp_code_in;
   end

   // samples captured on an encode transfer
   always_ff @(posedge clock) begin
      if (enc_xfer) begin
         samples_ff[0] <= req_sample_0;
         samples_ff[1] <= req_sample_1;
         samples_ff[2] <= req_sample_2;
         samples_ff[3] <= req_sample_3;
         samples_ff[4] <= req_sample_4;
         samples_ff[5] <= req_sample_5;
         samples_ff[6] <= req_sample_6;
         samples_ff[7] <= req_sample_7;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;

endmodule

// ----- rtl/psq_checker.sv -----
// Port-level checks for the product scalar quantiser encoder, and their bind.
// Depends on psq_pkg and product_scalar_quantizer_encoder_unit.
module psq_checker #(
   parameter int SAMPLE_BITS = psq_pkg::DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [psq_pkg::CODE_BITS-1:0] rsp_code
);

   // an encode transfer makes the block busy in the next cycle
   a_encode_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == psq_pkg::OP_ENCODE)) |=> req_stall)
      else $error("encode transfer not followed by busy");

   // a new result only appears after a busy cycle
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a preceding busy cycle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_code)))
      else $error("stalled result changed");

   // reset leaves the block idle with no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind product_scalar_quantizer_encoder_unit psq_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_psq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_code      (rsp_code)
);

// ----- tb/sv/psq_code_checker.sv -----
// Code checker for the product scalar quantiser encoder: watches the request,
// result and register ports, predicts each code and compares it on transfer.
// Depends on psq_pkg.
module psq_code_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic                                     req_operation,
   input  logic [psq_pkg::ENTRY_BITS-1:0]           req_entry_index,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_entry_value,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_0,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_1,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_2,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_3,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_4,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_5,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_6,
   input  logic signed [psq_pkg::DEF_SAMPLE_BITS-1:0] req_sample_7,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic [psq_pkg::CODE_BITS-1:0]            rsp_code,
   input  logic                                     csr_wr_en,
   input  logic                                     csr_index,
   input  logic [psq_pkg::CFG_BITS-1:0]             csr_wr_data,
   output int                                       fail_count,
   output int                                       codes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB    = psq_pkg::DEF_SAMPLE_BITS;
   localparam int DEPTH = psq_pkg::DEF_TABLE_DEPTH;

   // predictor state: codeword table and register copies
   logic signed [SB-1:0]           cw_table [DEPTH];
   logic [psq_pkg::CFG_BITS-1:0]   bits_reg;
   logic [psq_pkg::CFG_BITS-1:0]   dims_reg;
   logic [psq_pkg::CODE_BITS-1:0]  expected_codes [$];

   // binary search per sample over midpoints, indices packed low sample first
   function automatic logic [psq_pkg::CODE_BITS-1:0] quantise_subvector(
      input logic [8*SB-1:0] smp);
      int b;
      int dims;
      int count;
      int lo;
      int hi;
      int mid;
      int s;
      logic [63:0] packed_code;
      b = (bits_reg > psq_pkg::BPD_MAX) ? int'(psq_pkg::BPD_MAX) : int'(bits_reg);
      dims = (int'(dims_reg) > psq_pkg::DEF_MAX_DIMS) ? psq_pkg::DEF_MAX_DIMS
                                                      : int'(dims_reg);
      count = 1 << b;
      if (count > DEPTH) count = DEPTH;
      packed_code = '0;
      for (int k = 0; k < dims; k++) begin
         s = int'($signed(smp[SB*k +: SB]));
         lo = 0;
         hi = count - 1;
         // a sample on a midpoint fails the strict test and goes up
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (2 * s < int'(cw_table[mid]) + int'(cw_table[mid+1])) hi = mid;
            else lo = mid + 1;
         end
         packed_code |= 64'(lo) << (k * b);
      end
      return packed_code[psq_pkg::CODE_BITS-1:0];
   endfunction

   initial begin
      fail_count    = 0;
      codes_pending = 0;
   end

   always @(posedge clock) begin
      logic [psq_pkg::CODE_BITS-1:0] want;
      if (reset) begin
         bits_reg = psq_pkg::BPD_RESET;
         dims_reg = psq_pkg::DIMS_RESET;
         expected_codes.delete();
      end else begin
         // register writes must only come while the block is idle; the block does not enforce it
         if (csr_wr_en) begin
            case (csr_index)
               psq_pkg::CSR_BITS_PER_DIM:  bits_reg = csr_wr_data;
               psq_pkg::CSR_SUBSPACE_DIMS: dims_reg = csr_wr_data;
               default: ;
            endcase
         end
         // request transfer: load updates the table, encode queues a code
         if (req_valid && !req_stall) begin
            if (req_operation == psq_pkg::OP_LOAD)
               cw_table[req_entry_index] = req_entry_value;
            else
               expected_codes.push_back(quantise_subvector({req_sample_7, req_sample_6,
                  req_sample_5, req_sample_4, req_sample_3, req_sample_2,
                  req_sample_1, req_sample_0}));
         end
         // result transfer against the oldest outstanding code
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               $error("code: unexpected result, actual %0h", rsp_code);
               fail_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_code !== want) begin
                  $error("code: expected %0h actual %0h", want, rsp_code);
                  fail_count++;
               end
            end
         end
      end
      codes_pending <= expected_codes.size();
   end

endmodule

// ----- tb/sv/tb_product_scalar_quantizer_encoder_unit.sv -----
// Testbench top for the product scalar quantiser encoder: clock, reset, request
// and register stimulus, result back-pressure, watchdog and verdict.
// Depends on psq_pkg, product_scalar_quantizer_encoder_unit and psq_code_checker.
module tb_product_scalar_quantizer_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB          = psq_pkg::DEF_SAMPLE_BITS;
   localparam int EB          = psq_pkg::ENTRY_BITS;
   localparam int ITEM_TARGET = 1300;
   localparam int SETTLE      = 8;
   localparam int IDLE_LIMIT  = 2000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_operation;
   logic [EB-1:0] req_entry_index;
   logic signed [SB-1:0] req_entry_value;
   logic signed [SB-1:0] req_sample_0, req_sample_1, req_sample_2, req_sample_3;
   logic signed [SB-1:0] req_sample_4, req_sample_5, req_sample_6, req_sample_7;
   logic rsp_valid;
   logic rsp_stall;
   logic [psq_pkg::CODE_BITS-1:0] rsp_code;
   logic csr_wr_en;
   logic csr_index;
   logic [psq_pkg::CFG_BITS-1:0] csr_wr_data;

   int fail_count;
   int codes_pending;
   int idle_cycles;
   int items_sent;
   int cur_count;
   bit no_gaps;

   // stimulus-side copy of the table, used only to aim samples at midpoints and codewords
   logic signed [SB-1:0] shadow_cw [psq_pkg::DEF_TABLE_DEPTH];

   product_scalar_quantizer_encoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_sample_0(req_sample_0), .req_sample_1(req_sample_1),
      .req_sample_2(req_sample_2), .req_sample_3(req_sample_3),
      .req_sample_4(req_sample_4), .req_sample_5(req_sample_5),
      .req_sample_6(req_sample_6), .req_sample_7(req_sample_7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_code(rsp_code),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   psq_code_checker u_code_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_sample_0(req_sample_0), .req_sample_1(req_sample_1),
      .req_sample_2(req_sample_2), .req_sample_3(req_sample_3),
      .req_sample_4(req_sample_4), .req_sample_5(req_sample_5),
      .req_sample_6(req_sample_6), .req_sample_7(req_sample_7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_code(rsp_code),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .codes_pending(codes_pending)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // watchdog: cycles without any transfer or register write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result back-pressure: short stalls mostly, a few long, long free stretches
   initial begin
      int len;
      bit hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 99) < 35);
         if (hold)
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         else
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(30, 150);
         rsp_stall <= hold;
         repeat (len) @(posedge clock);
      end
   end

   // one request transfer; returns at the edge that takes it
   task automatic send_item(input logic op, input logic [EB-1:0] idx,
                            input logic [SB-1:0] val, input logic [8*SB-1:0] smp);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_sample_0    <= smp[0*SB +: SB];
      req_sample_1    <= smp[1*SB +: SB];
      req_sample_2    <= smp[2*SB +: SB];
      req_sample_3    <= smp[3*SB +: SB];
      req_sample_4    <= smp[4*SB +: SB];
      req_sample_5    <= smp[5*SB +: SB];
      req_sample_6    <= smp[6*SB +: SB];
      req_sample_7    <= smp[7*SB +: SB];
      if (op == psq_pkg::OP_LOAD) shadow_cw[idx] = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // sender gap: mostly none or short, now and then long
   task automatic idle_gap();
      int r;
      int g;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) g = 0;
      else if (r < 90) g = $urandom_range(1, 3);
      else g = $urandom_range(8, 40);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // hold off until every outstanding code has come back, then settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (codes_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input int bits_val, input int dims_val);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= psq_pkg::CSR_BITS_PER_DIM;
      csr_wr_data <= bits_val[psq_pkg::CFG_BITS-1:0];
      @(posedge clock);
      csr_index   <= psq_pkg::CSR_SUBSPACE_DIMS;
      csr_wr_data <= dims_val[psq_pkg::CFG_BITS-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_count = 1 << ((bits_val > 8) ? 8 : bits_val);
   endtask

   // ascending table: spread over the range, dense with repeats, or pinned ends
   task automatic load_table(input int n, input int style);
      int span;
      int v;
      span = 65536 / n;
      v = -32768 + int'($urandom_range(0, 60000));
      for (int i = 0; i < n; i++) begin
         if (style == 1) v = v + int'($urandom_range(0, 3));
         else v = -32768 + i * span + int'($urandom_range(0, span - 1));
         if (style == 2 && i == 0) v = -32768;
         if (style == 2 && i == n - 1) v = 32767;
         send_item(psq_pkg::OP_LOAD, i[EB-1:0], v[SB-1:0],
                   {$urandom, $urandom, $urandom, $urandom});
         idle_gap();
      end
   endtask

   // sample: range ends, random, on or beside a midpoint, or on a codeword
   function automatic logic [SB-1:0] pick_sample(input int count);
      int r;
      int j;
      int v;
      r = $urandom_range(0, 9);
      v = int'($signed(16'($urandom)));
      if (r == 0) v = -32768;
      else if (r == 1) v = 32767;
      else if (r >= 5 && r <= 7 && count >= 2) begin
         j = $urandom_range(0, count - 2);
         v = ((int'(shadow_cw[j]) + int'(shadow_cw[j+1])) >>> 1)
             + int'($urandom_range(0, 2)) - 1;
      end else if (r >= 8) begin
         j = $urandom_range(0, count - 1);
         v = int'(shadow_cw[j]);
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SB-1:0];
   endfunction

   task automatic send_encode(input logic [8*SB-1:0] smp);
      send_item(psq_pkg::OP_ENCODE, EB'($urandom), SB'($urandom), smp);
      idle_gap();
   endtask

   task automatic send_random_encode();
      logic [8*SB-1:0] smp;
      for (int k = 0; k < 8; k++) smp[SB*k +: SB] = pick_sample(cur_count);
      send_encode(smp);
   endtask

   // register settings for the directed part: reset values, ends, saturation
   int dir_bits [8] = '{4, 8, 0, 4, 15, 1, 9, 3};
   int dir_dims [8] = '{2, 1, 8, 0, 15, 8, 3, 8};

   initial begin
      int bits_val;
      int dims_val;
      int len;
      int pause_at;
      int ph;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = psq_pkg::OP_LOAD;
      req_entry_index = '0;
      req_entry_value = '0;
      req_sample_0    = '0;
      req_sample_1    = '0;
      req_sample_2    = '0;
      req_sample_3    = '0;
      req_sample_4    = '0;
      req_sample_5    = '0;
      req_sample_6    = '0;
      req_sample_7    = '0;
      csr_wr_en       = 1'b0;
      csr_index       = psq_pkg::CSR_BITS_PER_DIM;
      csr_wr_data     = '0;
      items_sent      = 0;
      no_gaps         = 1'b0;
      cur_count       = 16;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // whole table first, so no encode can ever read an unwritten entry
      load_table(psq_pkg::DEF_TABLE_DEPTH, 2);

      // directed: every sample at each end, then picked samples (ends, random, codewords, midpoints)
      for (int c = 0; c < 8; c++) begin
         if (c == 0) cur_count = 16;
         else set_config(dir_bits[c], dir_dims[c]);
         send_encode({8{16'sh8000}});
         send_encode({8{16'sh7fff}});
         send_random_encode();
      end

      // random phases: fresh settings, often a reloaded table, mostly encodes
      ph = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0:       bits_val = 0;
            1:       bits_val = 8;
            2:       bits_val = $urandom_range(9, 15);
            default: bits_val = $urandom_range(1, 7);
         endcase
         case ($urandom_range(0, 19))
            0:       dims_val = 0;
            1:       dims_val = $urandom_range(9, 15);
            default: dims_val = $urandom_range(1, 8);
         endcase
         set_config(bits_val, dims_val);
         if ((cur_count <= 64 && $urandom_range(0, 3) != 0) || $urandom_range(0, 6) == 0)
            load_table(cur_count, $urandom_range(0, 2));
         no_gaps = ($urandom_range(0, 4) == 0);
         len = $urandom_range(30, 70);
         pause_at = (ph == 0 || $urandom_range(0, 4) < 2) ? $urandom_range(1, len - 1) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == pause_at) wait_drained();
            // stray load: may leave the table out of order
            if ($urandom_range(0, 9) == 0) begin
               send_item(psq_pkg::OP_LOAD, EB'($urandom), SB'($urandom),
                         {$urandom, $urandom, $urandom, $urandom});
               idle_gap();
            end else begin
               send_random_encode();
            end
         end
         no_gaps = 1'b0;
         ph++;
      end

      wait_drained();
      if (fail_count == 0 && codes_pending == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
